// ===== hdl/im2col_pkg.sv =====
package im2col_pkg;

   // payload widths on the channels
   localparam int ADDR_OUT_W = 32;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;

   // clamped counts; wide enough for the largest MAX_* setting (65536)
   localparam int CNT_W = 17;

   // register map
   localparam logic [CSR_IDX_W-1:0] CSR_BATCH_COUNT   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CHANNEL_COUNT = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PADDED_HEIGHT = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_HEIGHT    = 4'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_WIDTH     = 4'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_HEIGHT = 4'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_KERNEL_WIDTH  = 4'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_STEP_SIZE     = 4'd7;

   // effective configuration seen by the datapath
   typedef struct packed {
      logic [CNT_W-1:0] batch;
      logic [CNT_W-1:0] chan;
      logic [CNT_W-1:0] out_h;
      logic [CNT_W-1:0] out_w;
      logic [CNT_W-1:0] ker_h;
      logic [CNT_W-1:0] ker_w;
      logic [12:0]      pad_h;
      logic [4:0]       stride;
   } im2col_cfg_type;

   // multiply-add sequence; src lands in acc a, dst in acc t
   typedef enum logic [3:0] {
      STEP_SX,   // a = x*s + kj
      STEP_SY,   // b = y*s + ki
      STEP_PH,   // a = a*ph + b
      STEP_CH,   // a = a*C + c
      STEP_M,    // a = a*M + i        (src)
      STEP_OW,   // t = y*OW + x
      STEP_TM,   // t = t*M + i
      STEP_TC,   // t = t*C
      STEP_TKH,  // t = t*KH
      STEP_RKH,  // b = c*KH + ki
      STEP_RKW,  // b = b*KW + kj      (row)
      STEP_DST   // t = t*KW + b       (dst)
   } im2col_step_type;

   typedef struct packed {
      logic            accept;
      logic            step_en;
      im2col_step_type step;
      logic            finish;
   } im2col_cmd_type;

   typedef struct packed {
      logic slot_free;
   } im2col_status_type;

endpackage

// ===== hdl/im2col_if.sv =====
interface im2col_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

interface im2col_rsp_if;
   import im2col_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ADDR_OUT_W-1:0] src_addr;
   logic [ADDR_OUT_W-1:0] dst_addr;
   logic                  last;

   modport source (output valid, output src_addr, output dst_addr, output last, input ready);
   modport sink   (input valid, input src_addr, input dst_addr, input last, output ready);
endinterface

interface im2col_csr_if;
   import im2col_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/im2col_csr.sv =====
module im2col_csr #(
   parameter int MAX_BATCH    = 256,
   parameter int MAX_CHANNELS = 1024,
   parameter int MAX_DIM      = 4096,
   parameter int MAX_KERNEL   = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               wr_valid,
   output logic                               wr_ready,
   input  logic [im2col_pkg::CSR_IDX_W-1:0]   wr_index,
   input  logic [im2col_pkg::CSR_DATA_W-1:0]  wr_data,
   output im2col_pkg::im2col_cfg_type         cfg
);
   import im2col_pkg::*;

   logic [8:0]  batch_ff,   batch_in;
   logic [10:0] chan_ff,    chan_in;
   logic [12:0] pad_h_ff,   pad_h_in;
   logic [12:0] out_h_ff,   out_h_in;
   logic [12:0] out_w_ff,   out_w_in;
   logic [4:0]  ker_h_ff,   ker_h_in;
   logic [4:0]  ker_w_ff,   ker_w_in;
   logic [4:0]  step_sz_ff, step_sz_in;

   // zero counts as one, saturate at the build limit
   function automatic logic [CNT_W-1:0] clamp_count(input logic [CSR_DATA_W-1:0] v,
                                                    input logic [CNT_W-1:0] maxv);
      logic [CNT_W-1:0] ve;
      ve = CNT_W'(v);
      if (ve == '0) begin
         return CNT_W'(1);
      end else if (ve > maxv) begin
         return maxv;
      end
      return ve;
   endfunction

   assign wr_ready = 1'b1;

   always_comb begin
      batch_in   = batch_ff;
      chan_in    = chan_ff;
      pad_h_in   = pad_h_ff;
      out_h_in   = out_h_ff;
      out_w_in   = out_w_ff;
      ker_h_in   = ker_h_ff;
      ker_w_in   = ker_w_ff;
      step_sz_in = step_sz_ff;
      if (wr_valid) begin
         case (wr_index)
            CSR_BATCH_COUNT:   batch_in   = wr_data[8:0];
            CSR_CHANNEL_COUNT: chan_in    = wr_data[10:0];
            CSR_PADDED_HEIGHT: pad_h_in   = wr_data[12:0];
            CSR_OUT_HEIGHT:    out_h_in   = wr_data[12:0];
            CSR_OUT_WIDTH:     out_w_in   = wr_data[12:0];
            CSR_KERNEL_HEIGHT: ker_h_in   = wr_data[4:0];
            CSR_KERNEL_WIDTH:  ker_w_in   = wr_data[4:0];
            CSR_STEP_SIZE:     step_sz_in = wr_data[4:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         batch_ff   <= 9'd1;
         chan_ff    <= 11'd1;
         pad_h_ff   <= 13'd1;
         out_h_ff   <= 13'd1;
         out_w_ff   <= 13'd1;
         ker_h_ff   <= 5'd1;
         ker_w_ff   <= 5'd1;
         step_sz_ff <= 5'd1;
      end else begin
         batch_ff   <= batch_in;
         chan_ff    <= chan_in;
         pad_h_ff   <= pad_h_in;
         out_h_ff   <= out_h_in;
         out_w_ff   <= out_w_in;
         ker_h_ff   <= ker_h_in;
         ker_w_ff   <= ker_w_in;
         step_sz_ff <= step_sz_in;
      end
   end

   assign cfg.batch  = clamp_count(CSR_DATA_W'(batch_ff), CNT_W'(MAX_BATCH));
   assign cfg.chan   = clamp_count(CSR_DATA_W'(chan_ff),  CNT_W'(MAX_CHANNELS));
   assign cfg.out_h  = clamp_count(CSR_DATA_W'(out_h_ff), CNT_W'(MAX_DIM));
   assign cfg.out_w  = clamp_count(CSR_DATA_W'(out_w_ff), CNT_W'(MAX_DIM));
   assign cfg.ker_h  = clamp_count(CSR_DATA_W'(ker_h_ff), CNT_W'(MAX_KERNEL));
   assign cfg.ker_w  = clamp_count(CSR_DATA_W'(ker_w_ff), CNT_W'(MAX_KERNEL));
   assign cfg.pad_h  = pad_h_ff;
   assign cfg.stride = step_sz_ff;

endmodule

// ===== hdl/im2col_ctrl.sv =====
module im2col_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  im2col_pkg::im2col_status_type status,
   output im2col_pkg::im2col_cmd_type    cmd
);
   import im2col_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_FINISH
   } state_type;

   state_type       state_ff, state_in;
   im2col_step_type step_ff,  step_in;

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in    = state_ff;
      step_in     = step_ff;
      cmd.accept  = 1'b0;
      cmd.step_en = 1'b0;
      cmd.step    = step_ff;
      cmd.finish  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               step_in    = STEP_SX;
               state_in   = ST_CALC;
            end
         end
         ST_CALC: begin
            cmd.step_en = 1'b1;
            if (step_ff == STEP_DST) begin
               state_in = ST_FINISH;
            end else begin
               step_in = im2col_step_type'(step_ff + 4'd1);
            end
         end
         ST_FINISH: begin
            // wait for the output register to drain
            if (status.slot_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         step_ff  <= STEP_SX;
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
      end
   end

endmodule

// ===== hdl/im2col_dp.sv =====
module im2col_dp #(
   parameter int ADDR_WIDTH   = 32,
   parameter int MAX_BATCH    = 256,
   parameter int MAX_CHANNELS = 1024,
   parameter int MAX_DIM      = 4096,
   parameter int MAX_KERNEL   = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  im2col_pkg::im2col_cfg_type          cfg,
   input  im2col_pkg::im2col_cmd_type          cmd,
   output im2col_pkg::im2col_status_type       status,
   input  logic                                req_restart,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [im2col_pkg::ADDR_OUT_W-1:0]   rsp_src_addr,
   output logic [im2col_pkg::ADDR_OUT_W-1:0]   rsp_dst_addr,
   output logic                                rsp_last
);
   import im2col_pkg::*;

   localparam int AW  = ADDR_WIDTH;
   localparam int BW  = (MAX_BATCH    > 1) ? $clog2(MAX_BATCH)    : 1;
   localparam int CW  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int DW  = (MAX_DIM      > 1) ? $clog2(MAX_DIM)      : 1;
   localparam int KW  = (MAX_KERNEL   > 1) ? $clog2(MAX_KERNEL)   : 1;

   // counter nest, outermost first
   logic [CW-1:0] chan_ff,  chan_in;
   logic [DW-1:0] orow_ff,  orow_in;
   logic [DW-1:0] ocol_ff,  ocol_in;
   logic [KW-1:0] krow_ff,  krow_in;
   logic [KW-1:0] kcol_ff,  kcol_in;
   logic [BW-1:0] batch_ff, batch_in;

   logic [AW-1:0] a_ff, b_ff, t_ff;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ADDR_OUT_W-1:0] src_ff, dst_ff;
   logic                  last_ff;

   logic [AW-1:0]       mul_a;
   logic [CNT_W-1:0]    mul_k;
   logic [AW-1:0]       add_v;
   logic [AW+CNT_W-1:0] prod_full;
   logic [AW-1:0]       mac;

   logic end_chan, end_orow, end_ocol, end_krow, end_kcol, end_batch;

   function automatic logic at_end(input logic [CNT_W-1:0] idx, input logic [CNT_W-1:0] cnt);
      return ((CNT_W+1)'(idx) + (CNT_W+1)'(1)) >= (CNT_W+1)'(cnt);
   endfunction

   // shared multiply-add: mac = mul_a * mul_k + add_v, mod 2^AW
   always_comb begin
      mul_a = '0;
      mul_k = '0;
      add_v = '0;
      case (cmd.step)
         STEP_SX: begin
            mul_a = AW'(ocol_ff);  mul_k = CNT_W'(cfg.stride); add_v = AW'(kcol_ff);
         end
         STEP_SY: begin
            mul_a = AW'(orow_ff);  mul_k = CNT_W'(cfg.stride); add_v = AW'(krow_ff);
         end
         STEP_PH: begin
            mul_a = a_ff;          mul_k = CNT_W'(cfg.pad_h);  add_v = b_ff;
         end
         STEP_CH: begin
            mul_a = a_ff;          mul_k = cfg.chan;           add_v = AW'(chan_ff);
         end
         STEP_M: begin
            mul_a = a_ff;          mul_k = cfg.batch;          add_v = AW'(batch_ff);
         end
         STEP_OW: begin
            mul_a = AW'(orow_ff);  mul_k = cfg.out_w;          add_v = AW'(ocol_ff);
         end
         STEP_TM: begin
            mul_a = t_ff;          mul_k = cfg.batch;          add_v = AW'(batch_ff);
         end
         STEP_TC: begin
            mul_a = t_ff;          mul_k = cfg.chan;
         end
         STEP_TKH: begin
            mul_a = t_ff;          mul_k = cfg.ker_h;
         end
         STEP_RKH: begin
            mul_a = AW'(chan_ff);  mul_k = cfg.ker_h;          add_v = AW'(krow_ff);
         end
         STEP_RKW: begin
            mul_a = b_ff;          mul_k = cfg.ker_w;          add_v = AW'(kcol_ff);
         end
         STEP_DST: begin
            mul_a = t_ff;          mul_k = cfg.ker_w;          add_v = b_ff;
         end
         default: ;
      endcase
   end

   assign prod_full = {{CNT_W{1'b0}}, mul_a} * {{AW{1'b0}}, mul_k};
   assign mac       = prod_full[AW-1:0] + add_v;

   always_ff @(posedge clock) begin
      if (cmd.step_en) begin
         case (cmd.step)
            STEP_SX, STEP_PH, STEP_CH, STEP_M:                  a_ff <= mac;
            STEP_SY, STEP_RKH, STEP_RKW:                        b_ff <= mac;
            STEP_OW, STEP_TM, STEP_TC, STEP_TKH, STEP_DST:      t_ff <= mac;
            default: ;
         endcase
      end
   end

   assign end_batch = at_end(CNT_W'(batch_ff), cfg.batch);
   assign end_kcol  = at_end(CNT_W'(kcol_ff),  cfg.ker_w);
   assign end_krow  = at_end(CNT_W'(krow_ff),  cfg.ker_h);
   assign end_ocol  = at_end(CNT_W'(ocol_ff),  cfg.out_w);
   assign end_orow  = at_end(CNT_W'(orow_ff),  cfg.out_h);
   assign end_chan  = at_end(CNT_W'(chan_ff),  cfg.chan);

   // clear the nest on restart, else advance it on finish; a counter at or past its last value wraps with a carry
   always_comb begin
      chan_in  = chan_ff;
      orow_in  = orow_ff;
      ocol_in  = ocol_ff;
      krow_in  = krow_ff;
      kcol_in  = kcol_ff;
      batch_in = batch_ff;
      if (cmd.accept && req_restart) begin
         chan_in  = '0;
         orow_in  = '0;
         ocol_in  = '0;
         krow_in  = '0;
         kcol_in  = '0;
         batch_in = '0;
      end else if (cmd.finish) begin
         batch_in = end_batch ? '0 : batch_ff + BW'(1);
         if (end_batch) begin
            kcol_in = end_kcol ? '0 : kcol_ff + KW'(1);
            if (end_kcol) begin
               krow_in = end_krow ? '0 : krow_ff + KW'(1);
               if (end_krow) begin
                  ocol_in = end_ocol ? '0 : ocol_ff + DW'(1);
                  if (end_ocol) begin
                     orow_in = end_orow ? '0 : orow_ff + DW'(1);
                     if (end_orow) begin
                        chan_in = end_chan ? '0 : chan_ff + CW'(1);
                     end
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff  <= '0;
         orow_ff  <= '0;
         ocol_ff  <= '0;
         krow_ff  <= '0;
         kcol_ff  <= '0;
         batch_ff <= '0;
      end else begin
         chan_ff  <= chan_in;
         orow_ff  <= orow_in;
         ocol_ff  <= ocol_in;
         krow_ff  <= krow_in;
         kcol_ff  <= kcol_in;
         batch_ff <= batch_in;
      end
   end

   // output register
   assign status.slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         src_ff  <= ADDR_OUT_W'(a_ff);
         dst_ff  <= ADDR_OUT_W'(t_ff);
         last_ff <= end_batch && end_kcol && end_krow && end_ocol && end_orow && end_chan;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_src_addr = src_ff;
   assign rsp_dst_addr = dst_ff;
   assign rsp_last     = last_ff;

endmodule

// ===== hdl/im2col_address_generator_top.sv =====
// channel | role           | beat
// req_if  | sink           | restart flag, one per address pair
// rsp_if  | source         | src_addr, dst_addr, last
// csr_if  | sink, always ready | register index and write data
//
// An item takes an accept step, twelve multiply-add steps through the single shared
// multiplier (address built by Horner evaluation) and a finish step that loads the
// output register and advances the counter nest. The next beat is taken the cycle after.
// A result waits in the output register; a stall there holds only the finish step.
// Synchronous reset zeroes the counters and sets every configuration register to 1.
module im2col_address_generator_top #(
   parameter int ADDR_WIDTH   = 32,
   parameter int MAX_BATCH    = 256,
   parameter int MAX_CHANNELS = 1024,
   parameter int MAX_DIM      = 4096,
   parameter int MAX_KERNEL   = 16
) (
   input logic          clock,
   input logic          reset,
   im2col_req_if.sink   req_if,
   im2col_rsp_if.source rsp_if,
   im2col_csr_if.sink   csr_if
);
   import im2col_pkg::*;

   im2col_cfg_type    cfg;
   im2col_cmd_type    cmd;
   im2col_status_type status;

   im2col_csr #(
      .MAX_BATCH    (MAX_BATCH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_DIM      (MAX_DIM),
      .MAX_KERNEL   (MAX_KERNEL)
   ) u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_if.valid),
      .wr_ready (csr_if.ready),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .cfg      (cfg)
   );

   im2col_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   im2col_dp #(
      .ADDR_WIDTH   (ADDR_WIDTH),
      .MAX_BATCH    (MAX_BATCH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_DIM      (MAX_DIM),
      .MAX_KERNEL   (MAX_KERNEL)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .cmd          (cmd),
      .status       (status),
      .req_restart  (req_if.restart),
      .rsp_valid    (rsp_if.valid),
      .rsp_ready    (rsp_if.ready),
      .rsp_src_addr (rsp_if.src_addr),
      .rsp_dst_addr (rsp_if.dst_addr),
      .rsp_last     (rsp_if.last)
   );

endmodule

// ===== hdl/im2col_checker.sv =====
module im2col_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_ready,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [im2col_pkg::ADDR_OUT_W-1:0]  rsp_src_addr,
   input logic [im2col_pkg::ADDR_OUT_W-1:0]  rsp_dst_addr,
   input logic                               rsp_last
);
   import im2col_pkg::*;

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_src_addr)
                                  && $stable(rsp_dst_addr) && $stable(rsp_last))
      else $error("rsp beat changed while stalled");

   // one item at a time: busy right after taking a beat
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req taken while previous item in flight");

   // a new result appears only after the busy finish step
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without work in flight");

   // reset empties the output and frees the input
   assert property (@(posedge clock)
      reset |=> !rsp_valid && req_ready)
      else $error("state not cleared by reset");

endmodule

bind im2col_address_generator_top im2col_checker u_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_if.valid),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .rsp_src_addr (rsp_if.src_addr),
   .rsp_dst_addr (rsp_if.dst_addr),
   .rsp_last     (rsp_if.last)
);

// ===== dv/tb_top.sv =====
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import im2col_pkg::*;

   localparam int ADDR_WIDTH   = 32;
   localparam int MAX_BATCH    = 256;
   localparam int MAX_CHANNELS = 1024;
   localparam int MAX_DIM      = 4096;
   localparam int MAX_KERNEL   = 16;

   localparam int ITEM_GOAL   = 1200;
   localparam int CALM_ITEMS  = 150;
   localparam int HOLD_CYCLES = 300;
   localparam int SETTLE_CYC  = 16;
   localparam int CYCLE_LIMIT = 500000;

   localparam logic [CSR_IDX_W-1:0] CSR_RESERVED_LO = CSR_IDX_W'(CSR_STEP_SIZE + 1);

   typedef struct packed {
      logic [ADDR_OUT_W-1:0] src_addr;
      logic [ADDR_OUT_W-1:0] dst_addr;
      logic                  last;
   } addr_pair_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  index;
      logic [CSR_DATA_W-1:0] data;
   } reg_write_type;

   logic clock = 1'b0;
   logic reset;

   im2col_req_if req_bus ();
   im2col_rsp_if rsp_bus ();
   im2col_csr_if csr_bus ();

   im2col_address_generator_top #(
      .ADDR_WIDTH   (ADDR_WIDTH),
      .MAX_BATCH    (MAX_BATCH),
      .MAX_CHANNELS (MAX_CHANNELS),
      .MAX_DIM      (MAX_DIM),
      .MAX_KERNEL   (MAX_KERNEL)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   always #4 clock = ~clock;

   // predictor copy of the register file
   logic [8:0]  cfg_batch;
   logic [10:0] cfg_chan;
   logic [12:0] cfg_pad_h;
   logic [12:0] cfg_out_h;
   logic [12:0] cfg_out_w;
   logic [4:0]  cfg_ker_h;
   logic [4:0]  cfg_ker_w;
   logic [4:0]  cfg_stride;

   // predictor copy of the counter nest
   longint unsigned pos_chan, pos_orow, pos_ocol, pos_krow, pos_kcol, pos_img;

   logic          pending_restarts[$];
   addr_pair_type expected_pairs[$];
   reg_write_type pending_writes[$];

   int   item_total = 0;
   int   err_cnt    = 0;
   int   cycle_cnt  = 0;
   int   req_gap    = 0;
   int   rsp_gap    = 0;
   int   hold_cnt   = 0;
   logic hold_kick  = 1'b0;
   logic calm       = 1'b0;

   function automatic longint unsigned saturate(longint unsigned v, longint unsigned top);
      if (v == 0) return 1;
      if (v > top) return top;
      return v;
   endfunction

   function automatic bit is_final(longint unsigned idx, longint unsigned cnt);
      return idx + 1 >= cnt;
   endfunction

   // step one counter, wrapping a counter at or past its last index; returns carry
   function automatic bit roll(inout longint unsigned idx, input longint unsigned cnt);
      if (is_final(idx, cnt)) begin
         idx = 0;
         return 1'b1;
      end
      idx = idx + 1;
      return 1'b0;
   endfunction

   function automatic addr_pair_type next_addr_pair(logic restart);
      longint unsigned m, ch, oh, ow, kh, kw, s, ph, src, dst, row, col;
      addr_pair_type p;
      m  = saturate(64'(cfg_batch), 64'(MAX_BATCH));
      ch = saturate(64'(cfg_chan), 64'(MAX_CHANNELS));
      oh = saturate(64'(cfg_out_h), 64'(MAX_DIM));
      ow = saturate(64'(cfg_out_w), 64'(MAX_DIM));
      kh = saturate(64'(cfg_ker_h), 64'(MAX_KERNEL));
      kw = saturate(64'(cfg_ker_w), 64'(MAX_KERNEL));
      s  = 64'(cfg_stride);
      ph = 64'(cfg_pad_h);
      if (restart) begin
         pos_chan = 0; pos_orow = 0; pos_ocol = 0;
         pos_krow = 0; pos_kcol = 0; pos_img = 0;
      end
      src = pos_img + m * (pos_chan + ch * ((s * pos_orow + pos_krow)
            + ph * (s * pos_ocol + pos_kcol)));
      row = pos_chan * kh * kw + pos_krow * kw + pos_kcol;
      col = pos_orow * ow * m + pos_ocol * m + pos_img;
      dst = row + ch * kh * kw * col;
      p.last = is_final(pos_chan, ch) && is_final(pos_orow, oh) &&
               is_final(pos_ocol, ow) && is_final(pos_krow, kh) &&
               is_final(pos_kcol, kw) && is_final(pos_img, m);
      if (roll(pos_img, m))
         if (roll(pos_kcol, kw))
            if (roll(pos_krow, kh))
               if (roll(pos_ocol, ow))
                  if (roll(pos_orow, oh))
                     void'(roll(pos_chan, ch));
      p.src_addr = src[ADDR_OUT_W-1:0];
      p.dst_addr = dst[ADDR_OUT_W-1:0];
      return p;
   endfunction

   // request driver; predicts on every accepted beat
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.restart <= 1'b0;
         pos_chan = 0; pos_orow = 0; pos_ocol = 0;
         pos_krow = 0; pos_kcol = 0; pos_img = 0;
      end else begin
         if (req_bus.valid && req_bus.ready)
            expected_pairs.push_back(next_addr_pair(req_bus.restart));
         if (!req_bus.valid || req_bus.ready) begin
            if (req_gap != 0) begin
               req_bus.valid <= 1'b0;
               req_gap = req_gap - 1;
            end else if (pending_restarts.size() != 0) begin
               req_bus.valid   <= 1'b1;
               req_bus.restart <= pending_restarts.pop_front();
               if (!calm && $urandom_range(0, 5) == 0)
                  req_gap = $urandom_range(1, 4);
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // register write driver
   always @(posedge clock) begin
      if (reset) begin
         csr_bus.valid <= 1'b0;
         cfg_batch  = 9'd1;  cfg_chan  = 11'd1; cfg_pad_h = 13'd1; cfg_out_h  = 13'd1;
         cfg_out_w  = 13'd1; cfg_ker_h = 5'd1;  cfg_ker_w = 5'd1;  cfg_stride = 5'd1;
      end else begin
         if (csr_bus.valid && csr_bus.ready) begin
            case (csr_bus.index)
               CSR_BATCH_COUNT:   cfg_batch  = csr_bus.data[8:0];
               CSR_CHANNEL_COUNT: cfg_chan   = csr_bus.data[10:0];
               CSR_PADDED_HEIGHT: cfg_pad_h  = csr_bus.data[12:0];
               CSR_OUT_HEIGHT:    cfg_out_h  = csr_bus.data[12:0];
               CSR_OUT_WIDTH:     cfg_out_w  = csr_bus.data[12:0];
               CSR_KERNEL_HEIGHT: cfg_ker_h  = csr_bus.data[4:0];
               CSR_KERNEL_WIDTH:  cfg_ker_w  = csr_bus.data[4:0];
               CSR_STEP_SIZE:     cfg_stride = csr_bus.data[4:0];
               default: ;
            endcase
         end
         if (!csr_bus.valid || csr_bus.ready) begin
            if (pending_writes.size() != 0) begin
               reg_write_type w;
               w = pending_writes.pop_front();
               csr_bus.valid <= 1'b1;
               csr_bus.index <= w.index;
               csr_bus.data  <= w.data;
            end else begin
               csr_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, started on request
   always @(posedge clock) begin
      if (reset) begin
         hold_cnt <= 0;
      end else if (hold_cnt != 0) begin
         hold_cnt <= hold_cnt - 1;
      end else if (hold_kick) begin
         hold_cnt  <= HOLD_CYCLES;
         hold_kick <= 1'b0;
      end
   end

   // result monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_pairs.size() == 0) begin
               $error("unexpected beat: src_addr %h dst_addr %h last %b",
                      rsp_bus.src_addr, rsp_bus.dst_addr, rsp_bus.last);
               err_cnt++;
            end else begin
               addr_pair_type e;
               e = expected_pairs.pop_front();
               if (rsp_bus.src_addr !== e.src_addr) begin
                  $error("src_addr: expected %h, actual %h", e.src_addr, rsp_bus.src_addr);
                  err_cnt++;
               end
               if (rsp_bus.dst_addr !== e.dst_addr) begin
                  $error("dst_addr: expected %h, actual %h", e.dst_addr, rsp_bus.dst_addr);
                  err_cnt++;
               end
               if (rsp_bus.last !== e.last) begin
                  $error("last: expected %b, actual %b", e.last, rsp_bus.last);
                  err_cnt++;
               end
            end
         end
         if (hold_cnt != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (rsp_gap != 0) begin
            rsp_bus.ready <= 1'b0;
            rsp_gap = rsp_gap - 1;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0)
               rsp_gap = $urandom_range(1, 4);
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   task automatic send(logic restart);
      pending_restarts.push_back(restart);
      item_total++;
   endtask

   task automatic set_reg(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      reg_write_type w;
      w.index = index;
      w.data  = data;
      pending_writes.push_back(w);
   endtask

   task automatic settle_regs();
      while (pending_writes.size() != 0 || csr_bus.valid) @(negedge clock);
   endtask

   // every beat sent and answered, then let the pipeline go quiet
   task automatic drain();
      while (pending_restarts.size() != 0 || req_bus.valid || expected_pairs.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYC) @(negedge clock);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] v;
      int  n, odds;
      bit  wide, held;
      held            = 1'b0;
      reset           = 1'b1;
      req_bus.valid   = 1'b0;
      req_bus.restart = 1'b0;
      rsp_bus.ready   = 1'b0;
      csr_bus.valid   = 1'b0;
      csr_bus.index   = '0;
      csr_bus.data    = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset configuration: every pair is the last one
      send(1'b0); send(1'b1);

      // zero counts behave as one, zero stride and padded height
      drain();
      for (int r = int'(CSR_BATCH_COUNT); r <= int'(CSR_STEP_SIZE); r++)
         set_reg(CSR_IDX_W'(r), '0);
      settle_regs();
      send(1'b0); send(1'b1);

      // all ones: counts saturate, stride and height at field max
      drain();
      for (int r = int'(CSR_BATCH_COUNT); r <= int'(CSR_STEP_SIZE); r++)
         set_reg(CSR_IDX_W'(r), '1);
      settle_regs();
      send(1'b1); send(1'b0); send(1'b0);

      // in-range maxima
      drain();
      set_reg(CSR_BATCH_COUNT, CSR_DATA_W'(MAX_BATCH));
      set_reg(CSR_CHANNEL_COUNT, CSR_DATA_W'(MAX_CHANNELS));
      set_reg(CSR_PADDED_HEIGHT, CSR_DATA_W'(MAX_DIM));
      set_reg(CSR_OUT_HEIGHT, CSR_DATA_W'(MAX_DIM));
      set_reg(CSR_OUT_WIDTH, CSR_DATA_W'(MAX_DIM));
      set_reg(CSR_KERNEL_HEIGHT, CSR_DATA_W'(MAX_KERNEL));
      set_reg(CSR_KERNEL_WIDTH, CSR_DATA_W'(MAX_KERNEL));
      set_reg(CSR_STEP_SIZE, CSR_DATA_W'(MAX_KERNEL));
      settle_regs();
      send(1'b1); send(1'b0);

      // small nest; writes past the register map must be ignored
      drain();
      set_reg(CSR_BATCH_COUNT, CSR_DATA_W'(3));
      set_reg(CSR_CHANNEL_COUNT, CSR_DATA_W'(1));
      set_reg(CSR_PADDED_HEIGHT, CSR_DATA_W'(3));
      set_reg(CSR_OUT_HEIGHT, CSR_DATA_W'(1));
      set_reg(CSR_OUT_WIDTH, CSR_DATA_W'(1));
      set_reg(CSR_KERNEL_HEIGHT, CSR_DATA_W'(1));
      set_reg(CSR_KERNEL_WIDTH, CSR_DATA_W'(2));
      set_reg(CSR_STEP_SIZE, CSR_DATA_W'(2));
      set_reg(CSR_RESERVED_LO, '0);
      set_reg('1, '0);
      settle_regs();
      send(1'b1); send(1'b0); send(1'b0); send(1'b0);

      // batch count shrunk below the live batch index, no restart
      drain();
      set_reg(CSR_BATCH_COUNT, CSR_DATA_W'(1));
      settle_regs();
      send(1'b0); send(1'b0);

      // four-pair reshape: last flag then wrap to the first pair
      drain();
      set_reg(CSR_CHANNEL_COUNT, CSR_DATA_W'(2));
      settle_regs();
      send(1'b1); send(1'b0); send(1'b0); send(1'b0); send(1'b0);

      while (item_total < ITEM_GOAL) begin
         drain();
         if (item_total >= ITEM_GOAL - CALM_ITEMS) calm = 1'b1;
         wide = ($urandom_range(0, 9) == 0);
         // partial rewrites leave counters beyond a shrunk count
         for (int r = int'(CSR_BATCH_COUNT); r <= int'(CSR_STEP_SIZE); r++) begin
            if ($urandom_range(0, 2) != 0) begin
               if (wide || $urandom_range(0, 15) == 0)
                  v = CSR_DATA_W'($urandom());
               else if (r == int'(CSR_PADDED_HEIGHT))
                  v = CSR_DATA_W'($urandom_range(0, 12));
               else if (r == int'(CSR_STEP_SIZE))
                  v = CSR_DATA_W'($urandom_range(0, 4));
               else
                  v = CSR_DATA_W'($urandom_range(1, 3));
               set_reg(CSR_IDX_W'(r), v);
            end
         end
         if ($urandom_range(0, 7) == 0)
            set_reg(CSR_IDX_W'(CSR_RESERVED_LO + $urandom_range(0, 7)),
                    CSR_DATA_W'($urandom()));
         settle_regs();
         // receiver stalls long while the sender keeps offering
         if (!held && item_total > 400) begin
            hold_kick = 1'b1;
            held      = 1'b1;
         end
         n    = wide ? $urandom_range(3, 10) : $urandom_range(30, 120);
         odds = ($urandom_range(0, 2) == 0) ? 6 : 60;
         if ($urandom_range(0, 1)) send(1'b1);
         for (int i = 0; i < n; i++) send($urandom_range(1, odds) == 1);
      end

      drain();
      repeat (20) @(negedge clock);
      if (err_cnt == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
